[rtl/infix_to_postfix_converter_top_assert.svh]
// Assertion macros for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define IFPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the following cycle.
`define IFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ifpc_pkg.sv]
// Package with constants, microcode types and the control store of the converter.
`default_nettype none

package ifpc_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    localparam logic [1:0] ST_OK              = 2'd0;
    localparam logic [1:0] ST_OVERFLOW        = 2'd1;
    localparam logic [1:0] ST_UNMATCHED_CLOSE = 2'd2;
    localparam logic [1:0] ST_UNMATCHED_OPEN  = 2'd3;

    typedef enum logic [4:0] {
        U_FETCH,
        U_EMIT_TOK,
        U_PUSH,
        U_C_RD,
        U_C_EV,
        U_C_DROP,
        U_C_EMIT,
        U_C_ERR,
        U_O_RD,
        U_O_EV,
        U_O_EMIT,
        U_FIN,
        U_REL,
        U_F_RD,
        U_F_EV,
        U_F_DROP,
        U_F_EMIT,
        U_F_DONE,
        U_F_OPEN,
        U_F_LAST
    } upc_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_TOKEN,
        EM_TOP,
        EM_STATUS
    } emit_t;

    typedef enum logic [2:0] {
        CD_NEVER,
        CD_EMPTY,
        CD_TOP_OPEN,
        CD_TOP_GE,
        CD_END,
        CD_OPEN_LEFT
    } cond_t;

    typedef struct packed {
        logic       accept;
        logic       dispatch;
        logic       push;
        logic       pop;
        logic       set_open;
        logic       release_pend;
        logic       finalize;
        emit_t      emit;
        logic [1:0] status;
        cond_t      cond;
        upc_t       tgt_t;
        upc_t       tgt_f;
    } ctrl_t;

    function automatic logic [2:0] prec_of(logic [7:0] c);
        logic [2:0] p;
        if (c == CH_POW) p = 3'd4;
        else if (c == CH_MUL || c == CH_DIV) p = 3'd3;
        else if (c == CH_ADD || c == CH_SUB) p = 3'd2;
        else if (c == CH_OPEN) p = 3'd1;
        else p = 3'd0;
        return p;
    endfunction

    function automatic logic is_op(logic [7:0] c);
        return c == CH_POW || c == CH_MUL || c == CH_DIV || c == CH_ADD || c == CH_SUB;
    endfunction

    function automatic ctrl_t ucode(upc_t pc);
        ctrl_t c;
        c.accept       = 1'b0;
        c.dispatch     = 1'b0;
        c.push         = 1'b0;
        c.pop          = 1'b0;
        c.set_open     = 1'b0;
        c.release_pend = 1'b0;
        c.finalize     = 1'b0;
        c.emit         = EM_NONE;
        c.status       = ST_OK;
        c.cond         = CD_NEVER;
        c.tgt_t        = U_FETCH;
        c.tgt_f        = U_FETCH;
        unique case (pc)
            U_FETCH:
            begin
                c.accept   = 1'b1;
                c.dispatch = 1'b1;
            end
            U_EMIT_TOK:
            begin
                c.emit  = EM_TOKEN;
                c.tgt_f = U_FIN;
            end
            U_PUSH:
            begin
                c.push   = 1'b1;
                c.emit   = EM_STATUS;
                c.status = ST_OVERFLOW;
                c.tgt_f  = U_FIN;
            end
            U_C_RD:
            begin
                c.cond  = CD_EMPTY;
                c.tgt_t = U_C_ERR;
                c.tgt_f = U_C_EV;
            end
            U_C_EV:
            begin
                c.cond  = CD_TOP_OPEN;
                c.tgt_t = U_C_DROP;
                c.tgt_f = U_C_EMIT;
            end
            U_C_DROP:
            begin
                c.pop   = 1'b1;
                c.tgt_f = U_FIN;
            end
            U_C_EMIT:
            begin
                c.pop   = 1'b1;
                c.emit  = EM_TOP;
                c.tgt_f = U_C_RD;
            end
            U_C_ERR:
            begin
                c.emit   = EM_STATUS;
                c.status = ST_UNMATCHED_CLOSE;
                c.tgt_f  = U_FIN;
            end
            U_O_RD:
            begin
                c.cond  = CD_EMPTY;
                c.tgt_t = U_PUSH;
                c.tgt_f = U_O_EV;
            end
            U_O_EV:
            begin
                c.cond  = CD_TOP_GE;
                c.tgt_t = U_O_EMIT;
                c.tgt_f = U_PUSH;
            end
            U_O_EMIT:
            begin
                c.pop   = 1'b1;
                c.emit  = EM_TOP;
                c.tgt_f = U_O_RD;
            end
            U_FIN:
            begin
                c.cond  = CD_END;
                c.tgt_t = U_F_RD;
                c.tgt_f = U_REL;
            end
            U_REL:
            begin
                c.release_pend = 1'b1;
                c.tgt_f        = U_FETCH;
            end
            U_F_RD:
            begin
                c.cond  = CD_EMPTY;
                c.tgt_t = U_F_DONE;
                c.tgt_f = U_F_EV;
            end
            U_F_EV:
            begin
                c.cond  = CD_TOP_OPEN;
                c.tgt_t = U_F_DROP;
                c.tgt_f = U_F_EMIT;
            end
            U_F_DROP:
            begin
                c.pop      = 1'b1;
                c.set_open = 1'b1;
                c.tgt_f    = U_F_RD;
            end
            U_F_EMIT:
            begin
                c.pop   = 1'b1;
                c.emit  = EM_TOP;
                c.tgt_f = U_F_RD;
            end
            U_F_DONE:
            begin
                c.cond  = CD_OPEN_LEFT;
                c.tgt_t = U_F_OPEN;
                c.tgt_f = U_F_LAST;
            end
            U_F_OPEN:
            begin
                c.emit   = EM_STATUS;
                c.status = ST_UNMATCHED_OPEN;
                c.tgt_f  = U_F_LAST;
            end
            U_F_LAST:
            begin
                c.finalize = 1'b1;
                c.tgt_f    = U_FETCH;
            end
            default:
            begin
                c.tgt_f = U_FETCH;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/ifpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ifpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/infix_to_postfix_converter_top.sv]
// Top level of the infix to postfix converter: microcode sequencer, operator stack and output.
// The input channel takes one character request per item with an end-of-expression flag.
// The output channel returns postfix characters and status-only results; last_of_run
// marks the final result of an expression, and every expression ends with one.
// A microcoded sequencer walks each request through a short program held in a
// constant control store; the operator stack lives in a RAM with registered read.
// An operand passes from the fetch step through the token emit, the end check and the
// release step back to fetch; its character moves to the output register in the release
// step. Every stack entry that a request pops or inspects costs its own read and evaluate
// steps, because each top-of-stack read goes through the RAM's registered read port first.
// The end-of-expression flush reads, evaluates and pops each stacked entry in turn.
// A request is taken one at a time; ready is high only in the fetch step.
// Each result passes through a one-entry holding register and then the output
// register, so a stalled receiver holds the sequencer only when it must emit.
// Reset empties the stack and clears all valid flags; the stack RAM is not cleared.

`default_nettype none

module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = ifpc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] token_char,
    input  wire logic       end_of_expr,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            has_char,
    output logic [1:0]      status,
    output logic            last_of_run
);

    import ifpc_pkg::*;

    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

    upc_t               upc_reg, upc_next;
    ctrl_t              ctrl;
    logic [COUNT_W-1:0] count_reg, count_next, count_m1;
    logic               open_left_reg, open_left_next;
    logic [7:0]         token_reg, token_next;
    logic               end_reg, end_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_char_reg, pend_char_next;
    logic               pend_has_reg, pend_has_next;
    logic [1:0]         pend_status_reg, pend_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_has_reg, out_has_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               full;
    logic               empty;
    logic [7:0]         top_char;
    logic               cond_hit;
    logic               emit_active;
    logic               out_free;
    logic               stall;
    logic               go;
    logic               out_load;
    logic               ram_we;
    logic [7:0]         new_char;
    logic               new_has;
    logic [1:0]         new_status;

    assign ctrl     = ucode(upc_reg);
    assign full     = count_reg == COUNT_W'(STACK_DEPTH);
    assign empty    = count_reg == '0;
    assign count_m1 = count_reg - COUNT_W'(1);
    assign out_free = !out_valid_reg || out_ready;

    ifpc_ram #(
        .WIDTH(8),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(token_reg),
        .raddr(count_m1[ADDR_W-1:0]),
        .rdata(top_char)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            CD_NEVER:     cond_hit = 1'b0;
            CD_EMPTY:     cond_hit = empty;
            CD_TOP_OPEN:  cond_hit = top_char == CH_OPEN;
            CD_TOP_GE:    cond_hit = prec_of(top_char) >= prec_of(token_reg);
            CD_END:       cond_hit = end_reg;
            CD_OPEN_LEFT: cond_hit = open_left_reg;
            default:      cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        emit_active = (ctrl.emit != EM_NONE) && !(ctrl.push && !full);
        stall = (ctrl.accept && !in_valid)
             || (emit_active && pend_valid_reg && !out_free)
             || (ctrl.release_pend && pend_valid_reg && !out_free)
             || (ctrl.finalize && !out_free);
        go       = !stall;
        ram_we   = go && ctrl.push && !full;
        out_load = go && (((emit_active || ctrl.release_pend) && pend_valid_reg)
                          || ctrl.finalize);
        in_ready = ctrl.accept;
    end

    always_comb
    begin
        unique case (ctrl.emit)
            EM_TOKEN:
            begin
                new_char   = token_reg;
                new_has    = 1'b1;
                new_status = ST_OK;
            end
            EM_TOP:
            begin
                new_char   = top_char;
                new_has    = 1'b1;
                new_status = ST_OK;
            end
            EM_STATUS:
            begin
                new_char   = 8'd0;
                new_has    = 1'b0;
                new_status = ctrl.status;
            end
            default:
            begin
                new_char   = 8'd0;
                new_has    = 1'b0;
                new_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (go)
        begin
            if (ctrl.dispatch)
            begin
                priority if (token_char == CH_OPEN) upc_next = U_PUSH;
                else if (token_char == CH_CLOSE) upc_next = U_C_RD;
                else if (is_op(token_char)) upc_next = U_O_RD;
                else upc_next = U_EMIT_TOK;
            end
            else
            begin
                upc_next = cond_hit ? ctrl.tgt_t : ctrl.tgt_f;
            end
        end
    end

    always_comb
    begin
        count_next       = count_reg;
        open_left_next   = open_left_reg;
        token_next       = token_reg;
        end_next         = end_reg;
        pend_valid_next  = pend_valid_reg;
        pend_char_next   = pend_char_reg;
        pend_has_next    = pend_has_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        out_has_next     = out_has_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        if (go && ctrl.accept)
        begin
            token_next = token_char;
            end_next   = end_of_expr;
        end
        if (go && ctrl.pop)
        begin
            count_next = count_m1;
        end
        if (ram_we)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (go && ctrl.set_open)
        begin
            open_left_next = 1'b1;
        end
        if (go && ctrl.finalize)
        begin
            open_left_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = ctrl.finalize;
            if (pend_valid_reg)
            begin
                out_char_next   = pend_char_reg;
                out_has_next    = pend_has_reg;
                out_status_next = pend_status_reg;
            end
            else
            begin
                out_char_next   = 8'd0;
                out_has_next    = 1'b0;
                out_status_next = ST_OK;
            end
        end

        if (go && (ctrl.release_pend || ctrl.finalize))
        begin
            pend_valid_next = 1'b0;
        end
        if (go && emit_active)
        begin
            pend_valid_next  = 1'b1;
            pend_char_next   = new_char;
            pend_has_next    = new_has;
            pend_status_next = new_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg        <= U_FETCH;
            count_reg      <= '0;
            open_left_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            upc_reg        <= upc_next;
            count_reg      <= count_next;
            open_left_reg  <= open_left_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        token_reg       <= token_next;
        end_reg         <= end_next;
        pend_char_reg   <= pend_char_next;
        pend_has_reg    <= pend_has_next;
        pend_status_reg <= pend_status_next;
        out_char_reg    <= out_char_next;
        out_has_reg     <= out_has_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign has_char    = out_has_reg;
    assign status      = out_status_reg;
    assign last_of_run = out_last_reg;

`include "infix_to_postfix_converter_top_assert.svh"

    `IFPC_ASSERT_NOW(a_no_pend_at_fetch, upc_reg == U_FETCH, !pend_valid_reg, "Held result at fetch")
    `IFPC_ASSERT_NEXT(a_empty_after_run, upc_reg == U_F_LAST && go, count_reg == '0, "Stack not empty")
    `IFPC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= COUNT_W'(STACK_DEPTH), "Stack count too big")

endmodule

`default_nettype wire

[sim/tb_infix_to_postfix_converter_top.sv]
// Self-checking testbench of the infix to postfix converter: directed table, stack overflow, random expressions.
`timescale 1ns / 1ps

module tb_infix_to_postfix_converter_top;
    import ifpc_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int DIR_ROWS = 25;
    localparam int PHASE_ITEMS = 32;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 100;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic [1:0] st;
        logic       last;
    } postfix_res_t;

    typedef struct packed {
        logic [7:0]   tok;
        logic         eoe;
        logic         typed;
        postfix_res_t want;
    } dir_row_t;

    localparam postfix_res_t NO_RES = '0;
    localparam logic [7:0] SPECIALS [7] = '{CH_POW, CH_MUL, CH_DIV, CH_ADD, CH_SUB,
                                            CH_OPEN, CH_CLOSE};

    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{"a",      1'b0, 1'b1, '{"a", 1'b1, ST_OK, 1'b0}},
        '{CH_ADD,   1'b0, 1'b0, NO_RES},
        '{"b",      1'b0, 1'b0, NO_RES},
        '{CH_MUL,   1'b0, 1'b0, NO_RES},
        '{"c",      1'b0, 1'b0, NO_RES},
        '{CH_POW,   1'b0, 1'b0, NO_RES},
        '{"d",      1'b0, 1'b0, NO_RES},
        '{CH_SUB,   1'b0, 1'b0, NO_RES},
        '{"e",      1'b0, 1'b0, NO_RES},
        '{CH_DIV,   1'b0, 1'b0, NO_RES},
        '{CH_OPEN,  1'b0, 1'b0, NO_RES},
        '{"f",      1'b0, 1'b0, NO_RES},
        '{CH_CLOSE, 1'b0, 1'b0, NO_RES},
        '{"g",      1'b1, 1'b0, NO_RES},
        '{CH_CLOSE, 1'b1, 1'b1, '{8'h00, 1'b0, ST_UNMATCHED_CLOSE, 1'b1}},
        '{CH_OPEN,  1'b1, 1'b1, '{8'h00, 1'b0, ST_UNMATCHED_OPEN, 1'b1}},
        '{CH_ADD,   1'b1, 1'b1, '{CH_ADD, 1'b1, ST_OK, 1'b1}},
        '{8'h00,    1'b1, 1'b1, '{8'h00, 1'b1, ST_OK, 1'b1}},
        '{8'hFF,    1'b0, 1'b1, '{8'hFF, 1'b1, ST_OK, 1'b0}},
        '{CH_OPEN,  1'b0, 1'b0, NO_RES},
        '{CH_OPEN,  1'b0, 1'b0, NO_RES},
        '{"x",      1'b0, 1'b0, NO_RES},
        '{CH_ADD,   1'b1, 1'b0, NO_RES},
        '{CH_OPEN,  1'b0, 1'b0, NO_RES},
        '{CH_CLOSE, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] token_char = 8'h00;
    logic       end_of_expr = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       has_char;
    logic [1:0] status;
    logic       last_of_run;

    logic [7:0]   model_stack [STACK_DEPTH];
    int           model_depth = 0;
    postfix_res_t released_q [$];
    postfix_res_t postfix_q [$];

    int err_count = 0;
    int items_sent = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int stuck_cycles = 0;
    int results_seen = 0;

    infix_to_postfix_converter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .token_char  (token_char),
        .end_of_expr (end_of_expr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .has_char    (has_char),
        .status      (status),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic int rank_of(logic [7:0] c);
        if (c == CH_POW) return 4;
        if (c == CH_MUL || c == CH_DIV) return 3;
        if (c == CH_ADD || c == CH_SUB) return 2;
        if (c == CH_OPEN) return 1;
        return 0;
    endfunction

    function automatic void release_res(logic [7:0] ch, logic has, logic [1:0] st);
        released_q.push_back('{ch, has, st, 1'b0});
    endfunction

    function automatic void stack_push(logic [7:0] c);
        if (model_depth >= STACK_DEPTH)
        begin
            release_res(8'h00, 1'b0, ST_OVERFLOW);
        end
        else
        begin
            model_stack[model_depth] = c;
            model_depth++;
        end
    endfunction

    function automatic void convert_token(logic [7:0] tok, logic eoe);
        logic [7:0] top;
        bit         found;
        bit         open_left;
        released_q.delete();
        found = 1'b0;
        open_left = 1'b0;
        if (tok == CH_OPEN)
        begin
            stack_push(tok);
        end
        else if (tok == CH_CLOSE)
        begin
            while (model_depth > 0 && !found)
            begin
                model_depth--;
                top = model_stack[model_depth];
                if (top == CH_OPEN) found = 1'b1;
                else release_res(top, 1'b1, ST_OK);
            end
            if (!found) release_res(8'h00, 1'b0, ST_UNMATCHED_CLOSE);
        end
        else if (rank_of(tok) >= 2)
        begin
            while (model_depth > 0 && rank_of(model_stack[model_depth - 1]) >= rank_of(tok))
            begin
                model_depth--;
                release_res(model_stack[model_depth], 1'b1, ST_OK);
            end
            stack_push(tok);
        end
        else
        begin
            release_res(tok, 1'b1, ST_OK);
        end
        if (eoe)
        begin
            while (model_depth > 0)
            begin
                model_depth--;
                top = model_stack[model_depth];
                if (top == CH_OPEN) open_left = 1'b1;
                else release_res(top, 1'b1, ST_OK);
            end
            if (open_left) release_res(8'h00, 1'b0, ST_UNMATCHED_OPEN);
            if (released_q.size() == 0) release_res(8'h00, 1'b0, ST_OK);
            released_q[released_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic logic [7:0] pick_special();
        return SPECIALS[$urandom_range(0, 6)];
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (rank_of(c) != 0 || c == CH_CLOSE);
        return c;
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int want);
        $display("%0t: result %0d: %s is %0h, expected %0h", $realtime, results_seen, field,
                 got, want);
        err_count++;
    endtask

    task automatic send_token(input logic [7:0] tok, input logic eoe, input logic typed,
                              input postfix_res_t want);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        token_char <= tok;
        end_of_expr <= eoe;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        convert_token(tok, eoe);
        if (typed)
        begin
            postfix_q.push_back(want);
        end
        else
        begin
            foreach (released_q[i]) postfix_q.push_back(released_q[i]);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (postfix_q.size() != 0) @(posedge clk);
    endtask

    task automatic send_expression();
        logic [7:0] toks [$];
        int         kind;
        int         goal;
        int         depth;
        int         operands;
        int         max_depth;
        int         open_pct;
        bit         need_operand;
        kind = $urandom_range(0, 9);
        goal = $urandom_range(1, 10);
        if (kind == 0)
        begin
            repeat (goal)
                toks.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : pick_special());
        end
        else
        begin
            max_depth = ($urandom_range(0, 9) == 0) ? 40 : 4;
            open_pct = (max_depth > 4) ? 70 : 25;
            depth = 0;
            operands = 0;
            need_operand = 1'b1;
            while (need_operand || operands < goal)
            begin
                if (need_operand)
                begin
                    if (depth < max_depth && $urandom_range(0, 99) < open_pct)
                    begin
                        toks.push_back(CH_OPEN);
                        depth++;
                    end
                    else
                    begin
                        toks.push_back(pick_operand());
                        operands++;
                        need_operand = 1'b0;
                    end
                end
                else if (depth > 0 && $urandom_range(0, 99) < 30)
                begin
                    toks.push_back(CH_CLOSE);
                    depth--;
                end
                else
                begin
                    toks.push_back(SPECIALS[$urandom_range(0, 4)]);
                    need_operand = 1'b1;
                end
            end
            if ($urandom_range(0, 19) != 0) repeat (depth) toks.push_back(CH_CLOSE);
            if (kind == 1) toks[$urandom_range(0, toks.size() - 1)] = pick_special();
        end
        foreach (toks[i]) send_token(toks[i], i == toks.size() - 1, 1'b0, NO_RES);
    endtask

    task automatic run_random(input int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) send_expression();
    endtask

    always @(posedge clk)
    begin
        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        postfix_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (postfix_q.size() == 0)
            begin
                flag_mismatch("unexpected out_char", out_char, 0);
            end
            else
            begin
                want = postfix_q.pop_front();
                if (out_char !== want.ch) flag_mismatch("out_char", out_char, want.ch);
                if (has_char !== want.has) flag_mismatch("has_char", has_char, want.has);
                if (status !== want.st) flag_mismatch("status", status, want.st);
                if (last_of_run !== want.last)
                    flag_mismatch("last_of_run", last_of_run, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
        else stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_token(DIR_TAB[i].tok, DIR_TAB[i].eoe, DIR_TAB[i].typed, DIR_TAB[i].want);
        drain_results();

        // Fill the stack to the top, overflow it, then close and flush it.
        for (int i = 0; i < STACK_DEPTH; i++)
            send_token((i % 2 == 0) ? CH_OPEN : CH_ADD, 1'b0, 1'b0, NO_RES);
        send_token(CH_MUL, 1'b0, 1'b0, NO_RES);
        send_token(CH_CLOSE, 1'b1, 1'b0, NO_RES);
        drain_results();

        hold_asked++;
        run_random(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 71;
        run_random(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 0;
        rx_stall_pct = 71;
        run_random(PHASE_ITEMS);
        drain_results();

        tx_idle_pct = 11;
        rx_stall_pct = 11;
        run_random(PHASE_ITEMS);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
